[hw/rtl/ibca_pkg.sv]
// Shared constants, widths and the arctangent table for the IMU bias/attitude block.
`timescale 1ns / 1ps
package ibca_pkg;

    localparam int CW       = 52;   // CORDIC vector width
    localparam int ZW       = 25;   // CORDIC angle width, 1/256 centidegree
    localparam int TAB_LEN  = 24;
    localparam int IDX_W    = 5;
    localparam int SQ_W     = 48;   // isqrt radicand width
    localparam int ROOT_W   = 24;
    localparam int YAW_W    = 26;   // Q9.16 degrees

    localparam logic signed [ZW-1:0]    QUARTER_TURN = 25'sd2304000;
    localparam logic signed [YAW_W-1:0] YAW_HALF     = 26'sd11796480;
    localparam logic signed [YAW_W-1:0] YAW_FULL     = 26'sd23592960;
    localparam logic signed [15:0]      ROLL_LIM     = 16'sd18000;
    localparam logic signed [15:0]      PITCH_LIM    = 16'sd9000;

    localparam logic [1:0] REG_CAL_SAMPLES = 2'd0;
    localparam logic [1:0] REG_DEADBAND    = 2'd1;
    localparam logic [1:0] REG_YAW_GAIN    = 2'd2;

    localparam logic [12:0] CAL_SAMPLES_RST = 13'd120;
    localparam logic [11:0] DEADBAND_RST    = 12'd4;
    localparam logic [15:0] YAW_GAIN_RST    = 16'd11735;

    // atan(2^-i) in 1/256 centidegree
    function automatic logic [20:0] atan_val(input logic [IDX_W-1:0] i);
        logic [20:0] v;
        case (i)
            5'd0:    v = 21'd1152000;
            5'd1:    v = 21'd680065;
            5'd2:    v = 21'd359328;
            5'd3:    v = 21'd182400;
            5'd4:    v = 21'd91554;
            5'd5:    v = 21'd45822;
            5'd6:    v = 21'd22916;
            5'd7:    v = 21'd11459;
            5'd8:    v = 21'd5730;
            5'd9:    v = 21'd2865;
            5'd10:   v = 21'd1432;
            5'd11:   v = 21'd716;
            5'd12:   v = 21'd358;
            5'd13:   v = 21'd179;
            5'd14:   v = 21'd90;
            5'd15:   v = 21'd45;
            5'd16:   v = 21'd22;
            5'd17:   v = 21'd11;
            5'd18:   v = 21'd6;
            5'd19:   v = 21'd3;
            5'd20:   v = 21'd1;
            5'd21:   v = 21'd1;
            default: v = 21'd0;
        endcase
        return v;
    endfunction

endpackage

[hw/rtl/imu_bias_cal_attitude_top.sv]
// Top level of the IMU gyro bias calibration and attitude block.
// A calibration word that is not the last only adds to the sums; the last one starts the
// bit-serial divider once per axis. An attitude word runs the shared CORDIC unit twice and
// the 24-step square root. One word is in work at a time.
// Reset (rst_n, asynchronous, active low) restores the register defaults and restarts calibration.
`timescale 1ns / 1ps
module imu_bias_cal_attitude_top #(
    parameter int MAX_CAL_SAMPLES = 4096,
    parameter int CORDIC_STEPS    = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic signed [15:0] accel_x,
    input  logic signed [15:0] accel_y,
    input  logic signed [15:0] accel_z,
    input  logic signed [15:0] rate_x,
    input  logic signed [15:0] rate_y,
    input  logic signed [15:0] rate_z,
    output logic               out_valid,
    input  logic               out_stall,
    output logic               result_kind,
    output logic signed [15:0] bias_x,
    output logic signed [15:0] bias_y,
    output logic signed [15:0] bias_z,
    output logic signed [15:0] roll,
    output logic signed [14:0] pitch,
    output logic signed [15:0] yaw
);
    import ibca_pkg::*;

    localparam int CNT_W = $clog2(MAX_CAL_SAMPLES + 1);
    localparam int TGT_W = (CNT_W > 13) ? CNT_W : 13;
    localparam int SUM_W = 16 + CNT_W;

    typedef enum logic [3:0] {
        S_IDLE, S_DIV_GO, S_DIV_WAIT, S_EMIT_BIAS,
        S_ROLL_GO, S_ROLL_WAIT, S_SQY, S_SQZ, S_SQSUM, S_SQRT_WAIT,
        S_PITCH_GO, S_PITCH_WAIT, S_YMUL, S_YACC, S_YWRAP, S_EMIT_ATT
    } state_t;

    state_t state_reg;

    logic [12:0] cal_samples_reg;
    logic [11:0] deadband_reg;
    logic [15:0] yaw_gain_reg;

    logic                    calibrating_reg;
    logic [CNT_W-1:0]        sample_count_reg;
    logic signed [SUM_W-1:0] sums_reg [3];
    logic signed [15:0]      bias_reg [3];
    logic [1:0]              axis_reg;
    logic signed [YAW_W-1:0] yaw_acc_reg;

    logic signed [15:0]     ax_reg, ay_reg, az_reg;
    logic signed [16:0]     c2_reg;
    logic signed [33:0]     prod_reg;
    logic [31:0]            sq_reg;
    logic [ROOT_W-1:0]      mag_reg;
    logic signed [15:0]     roll_reg;
    logic signed [14:0]     pitch_reg;

    logic               out_valid_reg;
    logic               kind_reg;
    logic signed [15:0] obx_reg, oby_reg, obz_reg, oroll_reg, oyaw_reg;
    logic signed [14:0] opitch_reg;

    logic [TGT_W-1:0]   target;
    logic [CNT_W-1:0]   count_next;
    logic               accept;
    logic               out_free;
    logic               apb_wr;

    logic signed [16:0] mul_a, mul_b;
    logic               cor_start, cor_done;
    logic signed [CW-1:0] cor_x, cor_y;
    logic signed [15:0] cor_angle;
    logic               div_done;
    logic signed [15:0] div_q;
    logic               sqrt_done;
    logic [ROOT_W-1:0]  sqrt_root;
    logic [31:0]        sq_sum;
    logic signed [16:0] neg_ax;
    logic signed [33:0] step_round;
    logic signed [YAW_W-1:0] yaw_step;
    logic signed [YAW_W:0]   yaw_sum;
    logic signed [17:0] c2_wide;
    logic signed [17:0] db_wide;
    logic signed [32:0] yaw_scaled;
    logic signed [32:0] yaw_cd_full;

    assign pready = 1'b1;
    assign apb_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cal_samples_reg <= CAL_SAMPLES_RST;
            deadband_reg    <= DEADBAND_RST;
            yaw_gain_reg    <= YAW_GAIN_RST;
        end
        else if (apb_wr)
        begin
            case (paddr[3:2])
                REG_CAL_SAMPLES: cal_samples_reg <= pwdata[12:0];
                REG_DEADBAND:    deadband_reg    <= pwdata[11:0];
                REG_YAW_GAIN:    yaw_gain_reg    <= pwdata[15:0];
                default:         ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            REG_CAL_SAMPLES: prdata = {19'd0, cal_samples_reg};
            REG_DEADBAND:    prdata = {20'd0, deadband_reg};
            REG_YAW_GAIN:    prdata = {16'd0, yaw_gain_reg};
            default:         prdata = '0;
        endcase
    end

    // Calibration length: zero acts as one, and the count is capped at the build limit.
    always_comb
    begin
        if (cal_samples_reg == 13'd0)
        begin
            target = TGT_W'(1);
        end
        else if (TGT_W'(cal_samples_reg) > TGT_W'(MAX_CAL_SAMPLES))
        begin
            target = TGT_W'(MAX_CAL_SAMPLES);
        end
        else
        begin
            target = TGT_W'(cal_samples_reg);
        end
    end

    assign count_next = sample_count_reg + CNT_W'(1);
    assign in_stall   = (state_reg != S_IDLE);
    assign accept     = in_valid && (state_reg == S_IDLE);
    assign out_free   = !out_valid_reg || !out_stall;

    // Shared multiplier, product registered every cycle.
    always_comb
    begin
        case (state_reg)
            S_SQZ:
            begin
                mul_a = {az_reg[15], az_reg};
                mul_b = {az_reg[15], az_reg};
            end
            S_YMUL:
            begin
                mul_a = c2_reg;
                mul_b = {1'b0, yaw_gain_reg};
            end
            default:
            begin
                mul_a = {ay_reg[15], ay_reg};
                mul_b = {ay_reg[15], ay_reg};
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;
    end

    assign neg_ax    = -{ax_reg[15], ax_reg};
    assign cor_start = (state_reg == S_ROLL_GO) || (state_reg == S_PITCH_GO);
    always_comb
    begin
        if (state_reg == S_PITCH_GO)
        begin
            cor_x = {4'd0, mag_reg, 24'd0};
            cor_y = {{3{neg_ax[16]}}, neg_ax, 32'd0};
        end
        else
        begin
            cor_x = {{12{az_reg[15]}}, az_reg, 24'd0};
            cor_y = {{12{ay_reg[15]}}, ay_reg, 24'd0};
        end
    end

    ibca_cordic #(
        .STEPS (CORDIC_STEPS)
    ) u_cordic (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cor_start),
        .x_in  (cor_x),
        .y_in  (cor_y),
        .done  (cor_done),
        .angle (cor_angle)
    );

    ibca_div #(
        .SUM_W (SUM_W),
        .CNT_W (CNT_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (state_reg == S_DIV_GO),
        .dividend (sums_reg[axis_reg]),
        .divisor  (sample_count_reg),
        .done     (div_done),
        .quotient (div_q)
    );

    assign sq_sum = sq_reg + prod_reg[31:0];

    ibca_isqrt u_isqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .start (state_reg == S_SQSUM),
        .value ({sq_sum, 16'd0}),
        .done  (sqrt_done),
        .root  (sqrt_root)
    );

    assign step_round = prod_reg + 34'sd128;
    assign yaw_step   = YAW_W'(step_round >>> 8);
    assign yaw_sum    = {yaw_acc_reg[YAW_W-1], yaw_acc_reg} + {yaw_step[YAW_W-1], yaw_step};
    assign c2_wide    = {c2_reg[16], c2_reg};
    assign db_wide    = {6'd0, deadband_reg};
    assign yaw_scaled = 33'(yaw_acc_reg) * 33'sd100;
    assign yaw_cd_full = (yaw_scaled + 33'sd32768) >>> 16;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            calibrating_reg  <= 1'b1;
            sample_count_reg <= '0;
            for (int k = 0; k < 3; k++)
            begin
                sums_reg[k] <= '0;
                bias_reg[k] <= '0;
            end
            axis_reg      <= '0;
            yaw_acc_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            // The emit states set the valid flag themselves when the output is free.
            if (out_valid_reg && !out_stall && state_reg != S_EMIT_BIAS
                && state_reg != S_EMIT_ATT)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        if (calibrating_reg)
                        begin
                            sums_reg[0] <= sums_reg[0] + SUM_W'(rate_x);
                            sums_reg[1] <= sums_reg[1] + SUM_W'(rate_y);
                            sums_reg[2] <= sums_reg[2] + SUM_W'(rate_z);
                            sample_count_reg <= count_next;
                            if (TGT_W'(count_next) >= target)
                            begin
                                axis_reg  <= '0;
                                state_reg <= S_DIV_GO;
                            end
                        end
                        else
                        begin
                            state_reg <= S_ROLL_GO;
                        end
                    end
                end
                S_DIV_GO:
                begin
                    state_reg <= S_DIV_WAIT;
                end
                S_DIV_WAIT:
                begin
                    if (div_done)
                    begin
                        bias_reg[axis_reg] <= div_q;
                        if (axis_reg == 2'd2)
                        begin
                            calibrating_reg <= 1'b0;
                            state_reg       <= S_EMIT_BIAS;
                        end
                        else
                        begin
                            axis_reg  <= axis_reg + 2'd1;
                            state_reg <= S_DIV_GO;
                        end
                    end
                end
                S_ROLL_GO:
                begin
                    state_reg <= S_ROLL_WAIT;
                end
                S_ROLL_WAIT:
                begin
                    if (cor_done)
                    begin
                        state_reg <= S_SQY;
                    end
                end
                S_SQY:
                begin
                    state_reg <= S_SQZ;
                end
                S_SQZ:
                begin
                    state_reg <= S_SQSUM;
                end
                S_SQSUM:
                begin
                    state_reg <= S_SQRT_WAIT;
                end
                S_SQRT_WAIT:
                begin
                    if (sqrt_done)
                    begin
                        state_reg <= S_PITCH_GO;
                    end
                end
                S_PITCH_GO:
                begin
                    state_reg <= S_PITCH_WAIT;
                end
                S_PITCH_WAIT:
                begin
                    if (cor_done)
                    begin
                        state_reg <= S_YMUL;
                    end
                end
                S_YMUL:
                begin
                    state_reg <= S_YACC;
                end
                S_YACC:
                begin
                    if (c2_wide > db_wide || c2_wide < -db_wide)
                    begin
                        yaw_acc_reg <= yaw_sum[YAW_W-1:0];
                    end
                    state_reg <= S_YWRAP;
                end
                S_YWRAP:
                begin
                    if (yaw_acc_reg > YAW_HALF)
                    begin
                        yaw_acc_reg <= yaw_acc_reg - YAW_FULL;
                    end
                    else if (yaw_acc_reg < -YAW_HALF)
                    begin
                        yaw_acc_reg <= yaw_acc_reg + YAW_FULL;
                    end
                    state_reg <= S_EMIT_ATT;
                end
                S_EMIT_BIAS, S_EMIT_ATT:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // Working values and the output word.
    always_ff @(posedge clk)
    begin
        if (accept && !calibrating_reg)
        begin
            ax_reg <= accel_x;
            ay_reg <= accel_y;
            az_reg <= accel_z;
            c2_reg <= {rate_z[15], rate_z} - {bias_reg[2][15], bias_reg[2]};
        end
        if (state_reg == S_ROLL_WAIT && cor_done)
        begin
            if (cor_angle > ROLL_LIM)
            begin
                roll_reg <= ROLL_LIM;
            end
            else if (cor_angle < -ROLL_LIM)
            begin
                roll_reg <= -ROLL_LIM;
            end
            else
            begin
                roll_reg <= cor_angle;
            end
        end
        if (state_reg == S_SQZ)
        begin
            sq_reg <= prod_reg[31:0];
        end
        if (state_reg == S_SQRT_WAIT && sqrt_done)
        begin
            mag_reg <= sqrt_root;
        end
        if (state_reg == S_PITCH_WAIT && cor_done)
        begin
            if (cor_angle > PITCH_LIM)
            begin
                pitch_reg <= PITCH_LIM[14:0];
            end
            else if (cor_angle < -PITCH_LIM)
            begin
                pitch_reg <= -(PITCH_LIM[14:0]);
            end
            else
            begin
                pitch_reg <= cor_angle[14:0];
            end
        end
        if (state_reg == S_EMIT_BIAS && out_free)
        begin
            kind_reg   <= 1'b0;
            obx_reg    <= bias_reg[0];
            oby_reg    <= bias_reg[1];
            obz_reg    <= bias_reg[2];
            oroll_reg  <= '0;
            opitch_reg <= '0;
            oyaw_reg   <= '0;
        end
        if (state_reg == S_EMIT_ATT && out_free)
        begin
            kind_reg   <= 1'b1;
            obx_reg    <= '0;
            oby_reg    <= '0;
            obz_reg    <= '0;
            oroll_reg  <= roll_reg;
            opitch_reg <= pitch_reg;
            oyaw_reg   <= yaw_cd_full[15:0];
        end
    end

    assign out_valid   = out_valid_reg;
    assign result_kind = kind_reg;
    assign bias_x      = obx_reg;
    assign bias_y      = oby_reg;
    assign bias_z      = obz_reg;
    assign roll        = oroll_reg;
    assign pitch       = opitch_reg;
    assign yaw         = oyaw_reg;

`ifndef NO_ASSERTIONS
    a_cal_end_reports: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(calibrating_reg) |-> state_reg == S_EMIT_BIAS)
        else $error("calibration ended without a bias report");

    a_report_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !result_kind |-> roll == 16'sd0 && pitch == 15'sd0 && yaw == 16'sd0)
        else $error("bias report carries attitude data");

    a_angle_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && result_kind |-> roll <= 16'sd18000 && roll >= -16'sd18000
            && pitch <= 15'sd9000 && pitch >= -15'sd9000)
        else $error("attitude angle out of range");
`endif

endmodule

[hw/rtl/ibca_div.sv]
// Iterative signed-by-unsigned divider, one quotient bit per cycle, truncating.
`timescale 1ns / 1ps
module ibca_div #(
    parameter int SUM_W = 29,
    parameter int CNT_W = 13
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic signed [SUM_W-1:0] dividend,
    input  logic [CNT_W-1:0]        divisor,
    output logic                    done,
    output logic signed [15:0]      quotient
);
    localparam int STEP_W = $clog2(SUM_W + 1);

    logic                run_reg;
    logic                done_reg;
    logic                neg_reg;
    logic [STEP_W-1:0]   step_reg;
    logic [SUM_W-1:0]    quo_reg;
    logic [CNT_W:0]      rem_reg;
    logic [CNT_W-1:0]    dvs_reg;
    logic [CNT_W:0]      trial;
    logic [SUM_W-1:0]    quo_signed;

    assign trial = {rem_reg[CNT_W-1:0], quo_reg[SUM_W-1]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                run_reg <= 1'b1;
            end
            else if (run_reg && step_reg == STEP_W'(1))
            begin
                run_reg  <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            neg_reg  <= dividend[SUM_W-1];
            quo_reg  <= dividend[SUM_W-1] ? (-dividend) : dividend;
            rem_reg  <= '0;
            dvs_reg  <= divisor;
            step_reg <= STEP_W'(SUM_W);
        end
        else if (run_reg)
        begin
            step_reg <= step_reg - STEP_W'(1);
            if (trial >= {1'b0, dvs_reg})
            begin
                rem_reg <= trial - {1'b0, dvs_reg};
                quo_reg <= {quo_reg[SUM_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= trial;
                quo_reg <= {quo_reg[SUM_W-2:0], 1'b0};
            end
        end
    end

    assign quo_signed = neg_reg ? (-quo_reg) : quo_reg;
    assign quotient   = quo_signed[15:0];
    assign done       = done_reg;

endmodule

[hw/rtl/ibca_isqrt.sv]
// Iterative integer square root, one result bit per cycle.
`timescale 1ns / 1ps
module ibca_isqrt
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic [ibca_pkg::SQ_W-1:0]   value,
    output logic                     done,
    output logic [ibca_pkg::ROOT_W-1:0] root
);
    import ibca_pkg::*;

    logic            run_reg;
    logic            done_reg;
    logic [SQ_W-1:0] v_reg;
    logic [SQ_W-1:0] res_reg;
    logic [SQ_W-1:0] bit_reg;
    logic [SQ_W-1:0] cand;

    assign cand = res_reg + bit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                run_reg <= 1'b1;
            end
            else if (run_reg && bit_reg[0])
            begin
                run_reg  <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            v_reg   <= value;
            res_reg <= '0;
            bit_reg <= SQ_W'(1) << (SQ_W - 2);
        end
        else if (run_reg)
        begin
            bit_reg <= bit_reg >> 2;
            if (v_reg >= cand)
            begin
                v_reg   <= v_reg - cand;
                res_reg <= (res_reg >> 1) + bit_reg;
            end
            else
            begin
                res_reg <= res_reg >> 1;
            end
        end
    end

    assign root = res_reg[ROOT_W-1:0];
    assign done = done_reg;

endmodule

[hw/rtl/ibca_cordic.sv]
// Iterative vectoring CORDIC giving atan2 in centidegrees, one rotation per cycle.
`timescale 1ns / 1ps
module ibca_cordic #(
    parameter int STEPS = 16
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic signed [ibca_pkg::CW-1:0] x_in,
    input  logic signed [ibca_pkg::CW-1:0] y_in,
    output logic                         done,
    output logic signed [15:0]           angle
);
    import ibca_pkg::*;

    localparam int N = (STEPS < TAB_LEN) ? STEPS : TAB_LEN;

    logic                 run_reg;
    logic                 done_reg;
    logic                 zero_reg;
    logic [IDX_W-1:0]     idx_reg;
    logic signed [CW-1:0] x_reg;
    logic signed [CW-1:0] y_reg;
    logic signed [ZW-1:0] z_reg;
    logic signed [CW-1:0] xs;
    logic signed [CW-1:0] ys;
    logic signed [ZW-1:0] at;
    logic signed [ZW-1:0] zr;

    assign xs = x_reg >>> idx_reg;
    assign ys = y_reg >>> idx_reg;
    assign at = ZW'(atan_val(idx_reg));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                run_reg <= 1'b1;
            end
            else if (run_reg && idx_reg == IDX_W'(N - 1))
            begin
                run_reg  <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            zero_reg <= (x_in == '0) && (y_in == '0);
            idx_reg  <= '0;
            // A vector in the left half-plane is first turned by a quarter turn.
            if (x_in < 0)
            begin
                if (y_in >= 0)
                begin
                    x_reg <= y_in;
                    y_reg <= -x_in;
                    z_reg <= QUARTER_TURN;
                end
                else
                begin
                    x_reg <= -y_in;
                    y_reg <= x_in;
                    z_reg <= -QUARTER_TURN;
                end
            end
            else
            begin
                x_reg <= x_in;
                y_reg <= y_in;
                z_reg <= '0;
            end
        end
        else if (run_reg)
        begin
            idx_reg <= idx_reg + IDX_W'(1);
            if (y_reg >= 0)
            begin
                x_reg <= x_reg + ys;
                y_reg <= y_reg - xs;
                z_reg <= z_reg + at;
            end
            else
            begin
                x_reg <= x_reg - ys;
                y_reg <= y_reg + xs;
                z_reg <= z_reg - at;
            end
        end
    end

    assign zr    = (z_reg + ZW'(128)) >>> 8;
    assign angle = zero_reg ? 16'sd0 : zr[15:0];
    assign done  = done_reg;

endmodule
